FILE: hdl/rmq_pkg.sv
// rmq_pkg: shared types and constants for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int ELEM_W = 16;
   localparam int CAND_W = 18;
   localparam int DIFF_W = 17;
   localparam int NORM_W = 31;

   typedef enum logic [1:0] {
      PICK_W,
      PICK_X,
      PICK_Y,
      PICK_Z
   } pick_type;

endpackage

FILE: hdl/rmq_chan_if.sv
// rmq_req_if and rmq_rsp_if: valid/ready channels for matrix items and quaternion items
// depends on rmq_pkg
interface rmq_req_if import rmq_pkg::*; ;
   logic valid;
   logic ready;
   logic signed [ELEM_W-1:0] a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz;

   modport source (output valid, a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz,
                   input ready);
   modport sink (input valid, a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz,
                 output ready);
endinterface

interface rmq_rsp_if import rmq_pkg::*; ;
   logic valid;
   logic ready;
   logic signed [ELEM_W-1:0] q_w, q_x, q_y, q_z;

   modport source (output valid, q_w, q_x, q_y, q_z, input ready);
   modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

FILE: hdl/rmq_sqrt_pipe.sv
// rmq_sqrt_pipe: pipelined integer square root, one result bit per stage
// no dependencies; a tag travels alongside each item
module rmq_sqrt_pipe #(
   parameter int RDW = 32,
   parameter int TW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [RDW-1:0]         in_rad,
   input  logic [TW-1:0]          in_tag,
   output logic                   out_valid,
   output logic [(RDW+1)/2-1:0]   out_root,
   output logic [TW-1:0]          out_tag
);

   localparam int N = (RDW + 1) / 2;
   localparam int W2 = 2 * N;

   logic [W2-1:0] v_ff [N];
   logic [W2-1:0] res_ff [N];
   logic [TW-1:0] tag_ff [N];
   logic          valid_ff [N];

   logic [W2-1:0] v_src [N];
   logic [W2-1:0] res_src [N];
   logic [TW-1:0] tag_src [N];
   logic          valid_src [N];
   logic [W2-1:0] v_in [N];
   logic [W2-1:0] res_in [N];
   logic [W2:0]   trial [N];
   logic [W2:0]   bitv [N];

   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            v_src[k] = W2'(in_rad);
            res_src[k] = '0;
            tag_src[k] = in_tag;
            valid_src[k] = in_valid;
         end else begin
            v_src[k] = v_ff[k-1];
            res_src[k] = res_ff[k-1];
            tag_src[k] = tag_ff[k-1];
            valid_src[k] = valid_ff[k-1];
         end
         bitv[k] = (W2+1)'(1) << (2 * (N - 1 - k));
         trial[k] = (W2+1)'(res_src[k]) + bitv[k];
         if ((W2+1)'(v_src[k]) >= trial[k]) begin
            v_in[k] = W2'((W2+1)'(v_src[k]) - trial[k]);
            res_in[k] = W2'(((W2+1)'(res_src[k]) >> 1) + bitv[k]);
         end else begin
            v_in[k] = v_src[k];
            res_in[k] = res_src[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            v_ff[k] <= v_in[k];
            res_ff[k] <= res_in[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < N; k++) valid_ff[k] <= valid_src[k];
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root = N'(res_ff[N-1]);
   assign out_tag = tag_ff[N-1];

endmodule

FILE: hdl/rmq_div_pipe.sv
// rmq_div_pipe: pipelined restoring divider, several lanes over one shared divisor
// no dependencies; one quotient bit per stage, a tag travels alongside each item
module rmq_div_pipe #(
   parameter int LANES = 1,
   parameter int NW = 32,
   parameter int DW = 16,
   parameter int QB = 32,
   parameter int TW = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NW-1:0]    in_num,
   input  logic [DW-1:0]               in_den,
   input  logic [TW-1:0]               in_tag,
   output logic                        out_valid,
   output logic [LANES-1:0][QB-1:0]    out_quo,
   output logic [TW-1:0]               out_tag
);

   localparam int CW = (NW > DW + QB) ? NW : DW + QB;

   logic [LANES-1:0][NW-1:0] rem_ff [QB];
   logic [LANES-1:0][QB-1:0] quo_ff [QB];
   logic [DW-1:0]            den_ff [QB];
   logic [TW-1:0]            tag_ff [QB];
   logic                     valid_ff [QB];

   logic [LANES-1:0][NW-1:0] rem_src [QB];
   logic [LANES-1:0][QB-1:0] quo_src [QB];
   logic [DW-1:0]            den_src [QB];
   logic [TW-1:0]            tag_src [QB];
   logic                     valid_src [QB];
   logic [LANES-1:0][NW-1:0] rem_in [QB];
   logic [LANES-1:0][QB-1:0] quo_in [QB];
   logic [CW-1:0]            dsh [QB];

   always_comb begin
      for (int k = 0; k < QB; k++) begin
         if (k == 0) begin
            rem_src[k] = in_num;
            quo_src[k] = '0;
            den_src[k] = in_den;
            tag_src[k] = in_tag;
            valid_src[k] = in_valid;
         end else begin
            rem_src[k] = rem_ff[k-1];
            quo_src[k] = quo_ff[k-1];
            den_src[k] = den_ff[k-1];
            tag_src[k] = tag_ff[k-1];
            valid_src[k] = valid_ff[k-1];
         end
         dsh[k] = CW'(den_src[k]) << (QB - 1 - k);
         for (int j = 0; j < LANES; j++) begin
            if (CW'(rem_src[k][j]) >= dsh[k]) begin
               rem_in[k][j] = NW'(CW'(rem_src[k][j]) - dsh[k]);
               quo_in[k][j] = (quo_src[k][j] << 1) | QB'(1);
            end else begin
               rem_in[k][j] = rem_src[k][j];
               quo_in[k][j] = quo_src[k][j] << 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QB; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_src[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QB; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < QB; k++) valid_ff[k] <= valid_src[k];
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_quo = quo_ff[QB-1];
   assign out_tag = tag_ff[QB-1];

endmodule

FILE: hdl/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: Shepperd matrix to unit quaternion, fully pipelined
// stages: candidates, pick, radicand, square root, divide prep, divider, assemble, max,
// normalize, squares, sum, square root, divide prep, divider, saturate and output
// throughput one item per cycle unless an output item that is not taken stalls the whole
// pipeline; the square roots and dividers are one bit per stage; synchronous active-high
// reset empties the pipeline; depends on rmq_pkg, rmq_chan_if, rmq_sqrt_pipe and rmq_div_pipe
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   rmq_req_if.sink     req_ch,
   rmq_rsp_if.source   rsp_ch
);

   localparam int F = FRAC_BITS;
   localparam int RW = ((F + 1 > 17) ? F + 1 : 17) + 1;
   localparam int RSW = RW + 1;
   localparam int RDW = RW + F;
   localparam int SW = (RDW + 1) / 2;
   localparam int DMW = DIFF_W;
   localparam int N1W = ((DMW + F > SW) ? DMW + F : SW) + 1;
   localparam int QB1 = N1W;
   localparam int MW = (QB1 > SW) ? QB1 : SW;
   localparam int NWIDE = (MW > NORM_W) ? MW : NORM_W;
   localparam int KR = (MW > NORM_W) ? $clog2(MW - 30) : 0;
   localparam int NS = KR + 5;
   localparam int SQW = 2 * NORM_W;
   localparam int RTW = 32;
   localparam int N2W = NORM_W + F + 1;
   localparam int QB2 = F + 1;

   typedef struct packed {
      pick_type                 pick;
      logic [2:0]               neg;
      logic [2:0][DMW-1:0]      dabs;
   } t1_type;

   typedef struct packed {
      pick_type                 pick;
      logic [2:0]               neg;
      logic [SW-1:0]            big;
   } t2_type;

   typedef struct packed {
      logic [3:0]               neg;
      logic [3:0][NORM_W-1:0]   mag;
   } t3_type;

   logic en;

   // stage 1: candidates and off-diagonal terms
   logic                          s1_valid_ff;
   logic signed [CAND_W-1:0]      s1_cand_ff [4];
   logic signed [DIFF_W-1:0]      s1_d_ff [6];
   logic signed [CAND_W-1:0]      exx, eyy, ezz;

   // stage 2: pick
   logic                          s2_valid_ff;
   logic signed [CAND_W-1:0]      s2_best_ff, best_in;
   pick_type                      s2_pick_ff, pick_in;
   logic signed [DIFF_W-1:0]      s2_sel_ff [3];
   logic signed [DIFF_W-1:0]      sel_in [3];

   // stage 3: radicand and magnitudes
   logic                          s3_valid_ff;
   logic [RDW-1:0]                s3_rad_ff;
   t1_type                        s3_tag_ff, tag1_in;
   logic signed [RSW-1:0]         r_s;
   logic [RW-1:0]                 r_u;

   logic                          q1_valid;
   logic [SW-1:0]                 q1_root;
   t1_type                        q1_tag;

   // prep for first divide
   logic                          p1_valid_ff;
   logic [2:0][N1W-1:0]           p1_num_ff;
   logic [SW:0]                   p1_den_ff;
   t2_type                        p1_tag_ff, tag2_in;

   logic                          d1_valid;
   logic [2:0][QB1-1:0]           d1_quo;
   t2_type                        d1_tag;

   // assemble, max
   logic                          as_valid_ff;
   logic [MW-1:0]                 as_mag_ff [4];
   logic [3:0]                    as_neg_ff;
   logic [MW-1:0]                 mag_in [4];
   logic [3:0]                    neg_in;
   logic [MW-1:0]                 big_w;

   logic                          tp_valid_ff;
   logic [NWIDE-1:0]              tp_mag_ff [4];
   logic [NWIDE-1:0]              tp_top_ff;
   logic [3:0]                    tp_neg_ff;
   logic [MW-1:0]                 m01, m23;

   // normalize
   logic                          nm_valid_ff [NS];
   logic [NWIDE-1:0]              nm_mag_ff [NS][4];
   logic [NWIDE-1:0]              nm_top_ff [NS];
   logic [3:0]                    nm_neg_ff [NS];
   logic                          nm_valid_src [NS];
   logic [NWIDE-1:0]              nm_mag_src [NS][4];
   logic [NWIDE-1:0]              nm_top_src [NS];
   logic [3:0]                    nm_neg_src [NS];
   logic [NWIDE-1:0]              nm_mag_in [NS][4];
   logic [NWIDE-1:0]              nm_top_in [NS];

   // squares and sum
   logic                          sq_valid_ff;
   logic [SQW-1:0]                sq_ff [4];
   t3_type                        sq_tag_ff, tag3_in;
   logic                          sm_valid_ff;
   logic [63:0]                   sm_n2_ff;
   t3_type                        sm_tag_ff;

   logic                          q2_valid;
   logic [RTW-1:0]                q2_root;
   t3_type                        q2_tag;

   logic                          p2_valid_ff;
   logic [3:0][N2W-1:0]           p2_num_ff;
   logic [RTW-1:0]                p2_den_ff;
   logic [3:0]                    p2_neg_ff;

   logic                          d2_valid;
   logic [3:0][QB2-1:0]           d2_quo;
   logic [3:0]                    d2_neg;

   logic                          o_valid_ff;
   logic signed [ELEM_W-1:0]      o_q_ff [4];
   logic signed [ELEM_W-1:0]      oq_in [4];

   assign en = !o_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // stage 1
   assign exx = CAND_W'(req_ch.a_xx);
   assign eyy = CAND_W'(req_ch.a_yy);
   assign ezz = CAND_W'(req_ch.a_zz);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_cand_ff[0] <= exx + eyy + ezz;
         s1_cand_ff[1] <= exx - eyy - ezz;
         s1_cand_ff[2] <= eyy - exx - ezz;
         s1_cand_ff[3] <= ezz - exx - eyy;
         s1_d_ff[0] <= DIFF_W'(req_ch.a_yz) - DIFF_W'(req_ch.a_zy);
         s1_d_ff[1] <= DIFF_W'(req_ch.a_zx) - DIFF_W'(req_ch.a_xz);
         s1_d_ff[2] <= DIFF_W'(req_ch.a_xy) - DIFF_W'(req_ch.a_yx);
         s1_d_ff[3] <= DIFF_W'(req_ch.a_xy) + DIFF_W'(req_ch.a_yx);
         s1_d_ff[4] <= DIFF_W'(req_ch.a_zx) + DIFF_W'(req_ch.a_xz);
         s1_d_ff[5] <= DIFF_W'(req_ch.a_yz) + DIFF_W'(req_ch.a_zy);
      end
   end

   // stage 2: ties keep the earlier candidate
   always_comb begin
      best_in = s1_cand_ff[0];
      pick_in = PICK_W;
      if (s1_cand_ff[1] > best_in) begin
         best_in = s1_cand_ff[1];
         pick_in = PICK_X;
      end
      if (s1_cand_ff[2] > best_in) begin
         best_in = s1_cand_ff[2];
         pick_in = PICK_Y;
      end
      if (s1_cand_ff[3] > best_in) begin
         best_in = s1_cand_ff[3];
         pick_in = PICK_Z;
      end
      case (pick_in)
         PICK_W: begin
            sel_in[0] = s1_d_ff[0];
            sel_in[1] = s1_d_ff[1];
            sel_in[2] = s1_d_ff[2];
         end
         PICK_X: begin
            sel_in[0] = s1_d_ff[0];
            sel_in[1] = s1_d_ff[3];
            sel_in[2] = s1_d_ff[4];
         end
         PICK_Y: begin
            sel_in[0] = s1_d_ff[1];
            sel_in[1] = s1_d_ff[3];
            sel_in[2] = s1_d_ff[5];
         end
         default: begin
            sel_in[0] = s1_d_ff[2];
            sel_in[1] = s1_d_ff[4];
            sel_in[2] = s1_d_ff[5];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_best_ff <= best_in;
         s2_pick_ff <= pick_in;
         for (int j = 0; j < 3; j++) s2_sel_ff[j] <= sel_in[j];
      end
   end

   // stage 3: radicand clamped to one lsb
   always_comb begin
      r_s = RSW'(s2_best_ff) + (RSW'(1) << F);
      if (r_s < RSW'(1)) begin
         r_u = RW'(1);
      end else begin
         r_u = RW'(r_s);
      end
      tag1_in.pick = s2_pick_ff;
      for (int j = 0; j < 3; j++) begin
         tag1_in.neg[j] = s2_sel_ff[j][DIFF_W-1];
         if (s2_sel_ff[j][DIFF_W-1]) begin
            tag1_in.dabs[j] = DMW'(-s2_sel_ff[j]);
         end else begin
            tag1_in.dabs[j] = DMW'(s2_sel_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_rad_ff <= RDW'(r_u) << F;
         s3_tag_ff <= tag1_in;
      end
   end

   rmq_sqrt_pipe #(.RDW(RDW), .TW($bits(t1_type))) u_sqrt1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_rad    (s3_rad_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (q1_valid),
      .out_root  (q1_root),
      .out_tag   (q1_tag)
   );

   // prep for first divide: num = |d| * 2^F + s, den = 2s
   always_comb begin
      tag2_in.pick = q1_tag.pick;
      tag2_in.neg = q1_tag.neg;
      tag2_in.big = SW'(((SW+1)'(q1_root) + (SW+1)'(1)) >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            p1_num_ff[j] <= (N1W'(q1_tag.dabs[j]) << F) + N1W'(q1_root);
         end
         p1_den_ff <= (SW+1)'(q1_root) << 1;
         p1_tag_ff <= tag2_in;
      end
   end

   rmq_div_pipe #(
      .LANES(3), .NW(N1W), .DW(SW + 1), .QB(QB1), .TW($bits(t2_type))
   ) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p1_valid_ff),
      .in_num    (p1_num_ff),
      .in_den    (p1_den_ff),
      .in_tag    (p1_tag_ff),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_tag   (d1_tag)
   );

   // place the biggest component at its slot
   assign big_w = MW'(d1_tag.big);

   always_comb begin
      case (d1_tag.pick)
         PICK_W: begin
            mag_in[0] = big_w;
            mag_in[1] = MW'(d1_quo[0]);
            mag_in[2] = MW'(d1_quo[1]);
            mag_in[3] = MW'(d1_quo[2]);
            neg_in = {d1_tag.neg, 1'b0};
         end
         PICK_X: begin
            mag_in[0] = MW'(d1_quo[0]);
            mag_in[1] = big_w;
            mag_in[2] = MW'(d1_quo[1]);
            mag_in[3] = MW'(d1_quo[2]);
            neg_in = {d1_tag.neg[2:1], 1'b0, d1_tag.neg[0]};
         end
         PICK_Y: begin
            mag_in[0] = MW'(d1_quo[0]);
            mag_in[1] = MW'(d1_quo[1]);
            mag_in[2] = big_w;
            mag_in[3] = MW'(d1_quo[2]);
            neg_in = {d1_tag.neg[2], 1'b0, d1_tag.neg[1:0]};
         end
         default: begin
            mag_in[0] = MW'(d1_quo[0]);
            mag_in[1] = MW'(d1_quo[1]);
            mag_in[2] = MW'(d1_quo[2]);
            mag_in[3] = big_w;
            neg_in = {1'b0, d1_tag.neg};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) as_mag_ff[i] <= mag_in[i];
         as_neg_ff <= neg_in;
      end
   end

   assign m01 = (as_mag_ff[1] > as_mag_ff[0]) ? as_mag_ff[1] : as_mag_ff[0];
   assign m23 = (as_mag_ff[3] > as_mag_ff[2]) ? as_mag_ff[3] : as_mag_ff[2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) tp_mag_ff[i] <= NWIDE'(as_mag_ff[i]);
         tp_top_ff <= NWIDE'((m23 > m01) ? m23 : m01);
         tp_neg_ff <= as_neg_ff;
      end
   end

   // normalize: right steps bring top below 2^31, left steps bring it to 2^30 or above
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            nm_valid_src[k] = tp_valid_ff;
            nm_top_src[k] = tp_top_ff;
            nm_neg_src[k] = tp_neg_ff;
            for (int i = 0; i < 4; i++) nm_mag_src[k][i] = tp_mag_ff[i];
         end else begin
            nm_valid_src[k] = nm_valid_ff[k-1];
            nm_top_src[k] = nm_top_ff[k-1];
            nm_neg_src[k] = nm_neg_ff[k-1];
            for (int i = 0; i < 4; i++) nm_mag_src[k][i] = nm_mag_ff[k-1][i];
         end
         nm_top_in[k] = nm_top_src[k];
         for (int i = 0; i < 4; i++) nm_mag_in[k][i] = nm_mag_src[k][i];
         if (k < KR) begin
            if (nm_top_src[k] >= (NWIDE'(1) << (30 + (1 << (KR - 1 - k))))) begin
               nm_top_in[k] = nm_top_src[k] >> (1 << (KR - 1 - k));
               for (int i = 0; i < 4; i++) begin
                  nm_mag_in[k][i] = nm_mag_src[k][i] >> (1 << (KR - 1 - k));
               end
            end
         end else begin
            if (nm_top_src[k] < (NWIDE'(1) << (31 - (1 << (4 - (k - KR)))))) begin
               nm_top_in[k] = nm_top_src[k] << (1 << (4 - (k - KR)));
               for (int i = 0; i < 4; i++) begin
                  nm_mag_in[k][i] = nm_mag_src[k][i] << (1 << (4 - (k - KR)));
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NS; k++) begin
            nm_top_ff[k] <= nm_top_in[k];
            nm_neg_ff[k] <= nm_neg_src[k];
            for (int i = 0; i < 4; i++) nm_mag_ff[k][i] <= nm_mag_in[k][i];
         end
      end
   end

   always_comb begin
      tag3_in.neg = nm_neg_ff[NS-1];
      for (int i = 0; i < 4; i++) tag3_in.mag[i] = NORM_W'(nm_mag_ff[NS-1][i]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            sq_ff[i] <= SQW'(tag3_in.mag[i]) * SQW'(tag3_in.mag[i]);
         end
         sq_tag_ff <= tag3_in;
         sm_n2_ff <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]) + 64'(sq_ff[3]);
         sm_tag_ff <= sq_tag_ff;
      end
   end

   rmq_sqrt_pipe #(.RDW(64), .TW($bits(t3_type))) u_sqrt2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sm_valid_ff),
      .in_rad    (sm_n2_ff),
      .in_tag    (sm_tag_ff),
      .out_valid (q2_valid),
      .out_root  (q2_root),
      .out_tag   (q2_tag)
   );

   // root is at least 2^30 here, never zero
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            p2_num_ff[i] <= (N2W'(q2_tag.mag[i]) << F) + N2W'(q2_root >> 1);
         end
         p2_den_ff <= q2_root;
         p2_neg_ff <= q2_tag.neg;
      end
   end

   rmq_div_pipe #(
      .LANES(4), .NW(N2W), .DW(RTW), .QB(QB2), .TW(4)
   ) u_div2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid_ff),
      .in_num    (p2_num_ff),
      .in_den    (p2_den_ff),
      .in_tag    (p2_neg_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_tag   (d2_neg)
   );

   // saturate to the output format
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (d2_neg[i]) begin
            if ((QB2+17)'(d2_quo[i]) > (QB2+17)'(32768)) begin
               oq_in[i] = ELEM_W'(-32768);
            end else begin
               oq_in[i] = ELEM_W'(0) - ELEM_W'(d2_quo[i]);
            end
         end else begin
            if ((QB2+17)'(d2_quo[i]) > (QB2+17)'(32767)) begin
               oq_in[i] = ELEM_W'(32767);
            end else begin
               oq_in[i] = ELEM_W'(d2_quo[i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) o_q_ff[i] <= oq_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         as_valid_ff <= 1'b0;
         tp_valid_ff <= 1'b0;
         for (int k = 0; k < NS; k++) nm_valid_ff[k] <= 1'b0;
         sq_valid_ff <= 1'b0;
         sm_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         p1_valid_ff <= q1_valid;
         as_valid_ff <= d1_valid;
         tp_valid_ff <= as_valid_ff;
         for (int k = 0; k < NS; k++) nm_valid_ff[k] <= nm_valid_src[k];
         sq_valid_ff <= nm_valid_ff[NS-1];
         sm_valid_ff <= sq_valid_ff;
         p2_valid_ff <= q2_valid;
         o_valid_ff <= d2_valid;
      end
   end

   assign rsp_ch.valid = o_valid_ff;
   assign rsp_ch.q_w = o_q_ff[0];
   assign rsp_ch.q_x = o_q_ff[1];
   assign rsp_ch.q_y = o_q_ff[2];
   assign rsp_ch.q_z = o_q_ff[3];

`ifndef SYNTH
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("pipeline stalled with no item at the output");
   a_take_moves_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("pipeline held while the output is taken");
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("output item present right after reset");
`endif

endmodule
